[src/block_mapping_flash_translation_core_macros.svh]
// Assertion macros used by the checker file.
`ifndef BLOCK_MAPPING_FLASH_TRANSLATION_CORE_MACROS_SVH
`define BLOCK_MAPPING_FLASH_TRANSLATION_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define BMFT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Implication checked in the cycle after the antecedent.
`define BMFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

[src/bmft_pkg.sv]
// ----------------------------------------------------------------------------
// bmft_pkg
// Types and command codes for the block-mapped flash translation core.
// ----------------------------------------------------------------------------
package bmft_pkg;
   localparam int CMD_W = 3;
   localparam int SEC_W = 11;
   localparam int PAGE_W = 11;
   localparam int BLK_W = 6;

   localparam int DATA_BLOCKS = 63;
   localparam int BLOCK_PAGES = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ  = 3'd0,
      CMD_PROG  = 3'd1,
      CMD_COPY  = 3'd2,
      CMD_TAG   = 3'd3,
      CMD_ERASE = 3'd4,
      CMD_ERR   = 3'd5
   } cmd_type;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef struct packed {
      logic             opcode;
      logic [SEC_W-1:0] sector_addr;
   } req_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [PAGE_W-1:0] target_page;
      logic [PAGE_W-1:0] source_page;
      logic [BLK_W-1:0]  erase_block_num;
      logic [BLK_W-1:0]  tag_block;
      logic [SEC_W-1:0]  tag_sector;
      logic              last;
   } rsp_type;
endpackage

[src/bmft_if.sv]
// ----------------------------------------------------------------------------
// bmft_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface bmft_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[src/block_mapping_flash_translation_core.sv]
// ----------------------------------------------------------------------------
// block_mapping_flash_translation_core
// Block-mapped flash translation: sector requests in, flash commands out.
//
//   channel  dir  fields
//   req      in   opcode, sector_addr
//   rsp      out  command, target_page, source_page, erase_block_num,
//                 tag_block, tag_sector, last
//
// The engine steps IDLE, FETCH, LOOK: a read emits in LOOK, a plain write goes
// on to PROG; an out-of-range read goes from IDLE to PROG, an out-of-range write
// is dropped in IDLE. A rebuild walks the old block through SCAN and COPY a page
// at a time, then ERASE, then clears its marks in CLR one page a cycle.
// Requests queue two deep ahead of the engine; a stalled rsp holds the engine.
// Reset is synchronous; the 2048 page marks then clear one a cycle, before the
// engine takes a request.
// ----------------------------------------------------------------------------
module block_mapping_flash_translation_core (
   input logic clock,
   input logic reset,
   bmft_if.sink   req,
   bmft_if.source rsp
);
   import bmft_pkg::*;
   logic    q_valid, q_ready;
   req_type q_data;

   bmft_queue u_queue (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   bmft_engine u_engine (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
   );
endmodule

[src/bmft_queue.sv]
// ----------------------------------------------------------------------------
// bmft_queue
// Two-entry queue between the request front and the command engine.
// ----------------------------------------------------------------------------
module bmft_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  bmft_pkg::req_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output bmft_pkg::req_type out_data
);
   import bmft_pkg::*;
   req_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_data;
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

[src/bmft_engine.sv]
// ----------------------------------------------------------------------------
// bmft_engine
// Walks one request: table lookup, allocation, rebuild, emits commands.
// ----------------------------------------------------------------------------
module bmft_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  bmft_pkg::req_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output bmft_pkg::rsp_type out_data
);
   import bmft_pkg::*;
   localparam int PHYS = DATA_BLOCKS + 1;
   localparam int PB_W = $clog2(PHYS);
   localparam int OFF_W = $clog2(BLOCK_PAGES);
   localparam int LB_W = $clog2(DATA_BLOCKS + 1);
   localparam int PG_W = $clog2(PHYS * BLOCK_PAGES);
   localparam int CNT_W = $clog2(BLOCK_PAGES + 1);

   typedef enum logic [8:0] {
      ST_INIT  = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_FETCH = 9'b000000100,
      ST_LOOK  = 9'b000001000,
      ST_SCAN  = 9'b000010000,
      ST_COPY  = 9'b000100000,
      ST_ERASE = 9'b001000000,
      ST_CLR   = 9'b010000000,
      ST_PROG  = 9'b100000000
   } state_type;

   state_type        state_ff;
   logic [PB_W-1:0]  map_ff [DATA_BLOCKS];
   logic [DATA_BLOCKS-1:0] mapv_ff;
   logic [PHYS-1:0]  use_ff;
   logic             pw_ff [PHYS*BLOCK_PAGES];
   logic [PB_W-1:0]  spare_ff;
   logic             op_ff;
   logic [SEC_W-1:0] lsn_ff;
   logic [LB_W-1:0]  lbn_ff;
   logic [OFF_W-1:0] off_ff;
   logic [PB_W-1:0]  pbn_ff, dst_ff, free_ff;
   logic             free_ok_ff;
   logic [CNT_W-1:0] idx_ff;
   logic [PG_W-1:0]  init_ff;
   logic             pwr_ff;
   logic [PG_W-1:0]  raddr;
   logic             rsp_v_ff;
   rsp_type          rsp_ff;
   logic             can_emit;
   logic [PB_W-1:0]  free_c;
   logic             free_ok_c;
   logic [SEC_W-1:0] lbn_full;

   assign can_emit  = !rsp_v_ff || out_ready;
   assign out_valid = rsp_v_ff;
   assign out_data  = rsp_ff;
   assign in_ready  = (state_ff == ST_IDLE);
   assign lbn_full  = SEC_W'(in_data.sector_addr / BLOCK_PAGES);

   // highest unused physical block, registered per request
   always_comb begin
      free_c = '0;
      free_ok_c = 1'b0;
      for (int j = 0; j < PHYS; j++) begin
         if (!use_ff[j]) begin
            free_c = PB_W'(j);
            free_ok_c = 1'b1;
         end
      end
   end

   function automatic logic [PG_W-1:0] pg(logic [PB_W-1:0] b, logic [OFF_W-1:0] o);
      return PG_W'(b) * PG_W'(BLOCK_PAGES) + PG_W'(o);
   endfunction

   function automatic rsp_type mk(cmd_type c, logic [PG_W-1:0] t, logic [PG_W-1:0] s,
                                  logic [PB_W-1:0] e, logic [LB_W-1:0] tb,
                                  logic [SEC_W-1:0] ts, logic l);
      rsp_type r;
      r.command = c;
      r.target_page = PAGE_W'(t);
      r.source_page = PAGE_W'(s);
      r.erase_block_num = BLK_W'(e);
      r.tag_block = BLK_W'(tb);
      r.tag_sector = ts;
      r.last = l;
      return r;
   endfunction

   always_comb begin
      raddr = pg(pbn_ff, off_ff);
      if (state_ff == ST_SCAN || state_ff == ST_COPY)
         raddr = pg(pbn_ff, OFF_W'(idx_ff));
   end

   always_ff @(posedge clock) begin
      pwr_ff <= pw_ff[raddr];
   end

   always_ff @(posedge clock) begin
      logic fire;
      fire = 1'b0;
      if (reset) begin
         state_ff <= ST_INIT;
         init_ff <= '0;
         mapv_ff <= '0;
         use_ff <= {1'b1, {(PHYS-1){1'b0}}};
         spare_ff <= PB_W'(DATA_BLOCKS);
         rsp_v_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_INIT: begin
               pw_ff[init_ff] <= 1'b0;
               init_ff <= init_ff + PG_W'(1);
               if (init_ff == PG_W'(PHYS*BLOCK_PAGES - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (in_valid) begin
                  op_ff <= in_data.opcode;
                  lsn_ff <= in_data.sector_addr;
                  off_ff <= OFF_W'(in_data.sector_addr % BLOCK_PAGES);
                  free_ff <= free_c;
                  free_ok_ff <= free_ok_c;
                  if (lbn_full >= SEC_W'(DATA_BLOCKS)) begin
                     if (in_data.opcode == OP_READ) state_ff <= ST_PROG;
                     else state_ff <= ST_IDLE;
                     lbn_ff <= '1;
                  end else begin
                     lbn_ff <= LB_W'(lbn_full);
                     pbn_ff <= map_ff[LB_W'(lbn_full)];
                     state_ff <= ST_FETCH;
                  end
               end
            end
            ST_FETCH: state_ff <= ST_LOOK;
            ST_LOOK: begin
               // pwr_ff holds page_written of mapped page
               if (op_ff == OP_READ) begin
                  if (can_emit) begin
                     fire = 1'b1;
                     rsp_ff <= mapv_ff[lbn_ff] ?
                        mk(CMD_READ, pg(pbn_ff, off_ff), '0, '0, '0, '0, 1'b1) :
                        mk(CMD_ERR, '0, '0, '0, '0, '0, 1'b1);
                     state_ff <= ST_IDLE;
                  end
               end else if (!mapv_ff[lbn_ff]) begin
                  if (!free_ok_ff) begin
                     state_ff <= ST_IDLE;
                  end else if (off_ff == '0) begin
                     use_ff[free_ff] <= 1'b1;
                     map_ff[lbn_ff] <= free_ff;
                     mapv_ff[lbn_ff] <= 1'b1;
                     dst_ff <= free_ff;
                     state_ff <= ST_PROG;
                  end else if (can_emit) begin
                     use_ff[free_ff] <= 1'b1;
                     map_ff[lbn_ff] <= free_ff;
                     mapv_ff[lbn_ff] <= 1'b1;
                     dst_ff <= free_ff;
                     fire = 1'b1;
                     rsp_ff <= mk(CMD_TAG, pg(free_ff, '0), '0, '0, lbn_ff, '0, 1'b0);
                     state_ff <= ST_PROG;
                  end
               end else if (!pwr_ff) begin
                  dst_ff <= pbn_ff;
                  state_ff <= ST_PROG;
               end else begin
                  dst_ff <= spare_ff;
                  idx_ff <= '0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: state_ff <= ST_COPY;
            ST_COPY: begin
               if (idx_ff == CNT_W'(BLOCK_PAGES)) begin
                  state_ff <= ST_ERASE;
               end else if (OFF_W'(idx_ff) == off_ff ||
                            (!pwr_ff && idx_ff != '0)) begin
                  idx_ff <= idx_ff + CNT_W'(1);
                  state_ff <= ST_SCAN;
               end else if (can_emit) begin
                  fire = 1'b1;
                  if (pwr_ff) begin
                     rsp_ff <= mk(CMD_COPY, pg(dst_ff, OFF_W'(idx_ff)),
                                  pg(pbn_ff, OFF_W'(idx_ff)), '0, lbn_ff, '0, 1'b0);
                     pw_ff[pg(dst_ff, OFF_W'(idx_ff))] <= 1'b1;
                  end else begin
                     rsp_ff <= mk(CMD_TAG, pg(dst_ff, '0), '0, '0, lbn_ff, '0, 1'b0);
                  end
                  idx_ff <= idx_ff + CNT_W'(1);
                  state_ff <= ST_SCAN;
               end
            end
            ST_ERASE: begin
               if (can_emit) begin
                  fire = 1'b1;
                  rsp_ff <= mk(CMD_ERASE, '0, '0, pbn_ff, '0, '0, 1'b0);
                  spare_ff <= pbn_ff;
                  map_ff[lbn_ff] <= dst_ff;
                  idx_ff <= '0;
                  state_ff <= ST_CLR;
               end
            end
            ST_CLR: begin
               pw_ff[pg(pbn_ff, OFF_W'(idx_ff))] <= 1'b0;
               idx_ff <= idx_ff + CNT_W'(1);
               if (idx_ff == CNT_W'(BLOCK_PAGES - 1)) state_ff <= ST_PROG;
            end
            ST_PROG: begin
               if (can_emit) begin
                  fire = 1'b1;
                  if (op_ff == OP_READ) begin
                     rsp_ff <= mk(CMD_ERR, '0, '0, '0, '0, '0, 1'b1);
                  end else begin
                     rsp_ff <= mk(CMD_PROG, pg(dst_ff, off_ff), '0, '0, lbn_ff,
                                  lsn_ff, 1'b1);
                     pw_ff[pg(dst_ff, off_ff)] <= 1'b1;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         rsp_v_ff <= fire || (rsp_v_ff && !out_ready);
      end
   end
endmodule

[src/bmft_checker.sv]
// ----------------------------------------------------------------------------
// bmft_checker
// Port-level checks on the translation core.
// ----------------------------------------------------------------------------
`include "block_mapping_flash_translation_core_macros.svh"
module bmft_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input bmft_pkg::rsp_type rsp_data
);
   import bmft_pkg::*;
   `BMFT_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data), "rsp word changed while stalled")
   `BMFT_ASSERT_IMP(a_code, clock, reset, rsp_valid, rsp_data.command <= CMD_ERR, "bad command code")
   `BMFT_ASSERT_IMP(a_err, clock, reset, rsp_valid && rsp_data.command == CMD_ERR, rsp_data.last && rsp_data.target_page == '0, "error word malformed")
   `BMFT_ASSERT_IMP(a_erase, clock, reset, rsp_valid && rsp_data.command == CMD_ERASE, !rsp_data.last, "erase word marked last")
endmodule

bind block_mapping_flash_translation_core bmft_checker u_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Checks the flash translation core: sector requests in, flash commands out.
// A local model of the block and page tables predicts each command word, and
// a checker compares every accepted rsp word with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
   import bmft_pkg::*;

   localparam int PHYS_BLOCKS = DATA_BLOCKS + 1;
   localparam int PHYS_PAGES  = PHYS_BLOCKS * BLOCK_PAGES;
   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bmft_if #(.payload_type(req_type)) req_ch ();
   bmft_if #(.payload_type(rsp_type)) rsp_ch ();

   block_mapping_flash_translation_core DUT (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   always #10 clock = ~clock;

   // model state
   logic [5:0] map_phys [DATA_BLOCKS];
   logic       map_valid [DATA_BLOCKS];
   logic [5:0] spare_blk;
   logic       blk_used [PHYS_BLOCKS];
   logic       pg_written [PHYS_PAGES];

   rsp_type cmd_queue [$];
   int      error_count = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   bit      hold_off = 1'b0;
   int      quiet_cycles = 0;

   function automatic rsp_type mk_cmd(cmd_type c, int tgt, int src, int ers,
                                      int tblk, int tsec);
      rsp_type r;
      r.command         = c;
      r.target_page     = tgt[PAGE_W-1:0];
      r.source_page     = src[PAGE_W-1:0];
      r.erase_block_num = ers[BLK_W-1:0];
      r.tag_block       = tblk[BLK_W-1:0];
      r.tag_sector      = tsec[SEC_W-1:0];
      r.last            = 1'b0;
      return r;
   endfunction

   task automatic tables_clear();
      for (int i = 0; i < DATA_BLOCKS; i++) begin
         map_phys[i] = '0;
         map_valid[i] = 1'b0;
      end
      for (int i = 0; i < PHYS_BLOCKS; i++) blk_used[i] = 1'b0;
      for (int i = 0; i < PHYS_PAGES; i++) pg_written[i] = 1'b0;
      spare_blk = 6'(DATA_BLOCKS);
      blk_used[DATA_BLOCKS] = 1'b1;
   endtask

   // predicts the commands for one request and pushes them
   task automatic translate(req_type rq);
      rsp_type cmds [$];
      int lbn, off, pbn, dst, fb, sp, tp;
      lbn = rq.sector_addr / BLOCK_PAGES;
      off = rq.sector_addr % BLOCK_PAGES;
      if (rq.opcode == OP_READ) begin
         if (lbn >= DATA_BLOCKS || !map_valid[lbn])
            cmds.push_back(mk_cmd(CMD_ERR, 0, 0, 0, 0, 0));
         else
            cmds.push_back(mk_cmd(CMD_READ, map_phys[lbn] * BLOCK_PAGES + off,
                                  0, 0, 0, 0));
      end else if (lbn < DATA_BLOCKS) begin
         dst = -1;
         if (!map_valid[lbn]) begin
            fb = -1;
            for (int j = PHYS_BLOCKS - 1; j >= 0 && fb < 0; j--)
               if (!blk_used[j]) fb = j;
            if (fb >= 0) begin
               blk_used[fb] = 1'b1;
               map_phys[lbn] = 6'(fb);
               map_valid[lbn] = 1'b1;
               dst = fb;
               if (off != 0)
                  cmds.push_back(mk_cmd(CMD_TAG, dst * BLOCK_PAGES, 0, 0, lbn, 0));
            end
         end else begin
            pbn = int'(map_phys[lbn]);
            dst = pbn;
            if (pg_written[pbn * BLOCK_PAGES + off]) begin
               dst = int'(spare_blk);
               for (int i = 0; i < BLOCK_PAGES; i++) begin
                  sp = pbn * BLOCK_PAGES + i;
                  tp = dst * BLOCK_PAGES + i;
                  if (i != off) begin
                     if (pg_written[sp]) begin
                        cmds.push_back(mk_cmd(CMD_COPY, tp, sp, 0, lbn, 0));
                        pg_written[tp] = 1'b1;
                     end else if (i == 0) begin
                        cmds.push_back(mk_cmd(CMD_TAG, tp, 0, 0, lbn, 0));
                     end
                  end
               end
               cmds.push_back(mk_cmd(CMD_ERASE, 0, 0, pbn, 0, 0));
               for (int i = 0; i < BLOCK_PAGES; i++)
                  pg_written[pbn * BLOCK_PAGES + i] = 1'b0;
               spare_blk = 6'(pbn);
               map_phys[lbn] = 6'(dst);
            end
         end
         if (dst >= 0) begin
            cmds.push_back(mk_cmd(CMD_PROG, dst * BLOCK_PAGES + off, 0, 0, lbn,
                                  rq.sector_addr));
            pg_written[dst * BLOCK_PAGES + off] = 1'b1;
         end
      end
      if (cmds.size() > 0) cmds[cmds.size()-1].last = 1'b1;
      foreach (cmds[i]) cmd_queue.push_back(cmds[i]);
   endtask

   task automatic send_req(logic op, int sector);
      req_type rq;
      rq.opcode = op;
      rq.sector_addr = sector[SEC_W-1:0];
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= rq;
      do @(posedge clock); while (!req_ch.ready);
      translate(rq);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (cmd_queue.size() > 0) @(posedge clock);
      repeat (3 * BLOCK_PAGES + 20) @(posedge clock);
   endtask

   // receiver ready
   always @(posedge clock) begin
      if (reset || hold_off)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // result checker
   always @(posedge clock) begin
      rsp_type exp_cmd;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (cmd_queue.size() == 0) begin
            $display("%0t: unexpected word %p", $time, rsp_ch.data);
            error_count++;
         end else begin
            exp_cmd = cmd_queue.pop_front();
            if (rsp_ch.data !== exp_cmd) begin
               $display("%0t: mismatch expected %p actual %p", $time, exp_cmd,
                        rsp_ch.data);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else if (!reset)
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   task automatic test_directed();
      send_req(OP_READ, 0);
      send_req(OP_READ, 2047);
      send_req(OP_WRITE, 2047);
      send_req(OP_WRITE, 2016);
      send_req(OP_WRITE, 0);
      send_req(OP_READ, 0);
      send_req(OP_READ, 1);
      send_req(OP_WRITE, 5);
      send_req(OP_WRITE, 5);
      send_req(OP_WRITE, 0);
      send_req(OP_WRITE, 2015);
      send_req(OP_WRITE, 2015);
      send_req(OP_READ, 2015);
      send_req(OP_WRITE, 1023);
      send_req(OP_WRITE, 1024);
      send_req(OP_READ, 1024);
      send_req(OP_WRITE, 31);
      for (int i = 1; i < BLOCK_PAGES; i++) send_req(OP_WRITE, 64 + i);
      send_req(OP_WRITE, 64 + 7);
      send_req(OP_READ, 2016);
   endtask

   task automatic test_random(int count);
      int lbn;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(9) == 0) begin
            send_req(1'($urandom_range(1)), $urandom_range(2047));
         end else begin
            // a few hot blocks so rewrites happen often
            lbn = ($urandom_range(3) == 0) ? $urandom_range(DATA_BLOCKS - 1)
                                           : $urandom_range(5) * 11;
            send_req(1'($urandom_range(1)), lbn * BLOCK_PAGES
                     + $urandom_range(BLOCK_PAGES - 1));
         end
      end
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_off = 1'b1;
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            for (int i = 0; i < 12; i++)
               send_req(OP_WRITE, 11 * BLOCK_PAGES + $urandom_range(3));
         end
      join
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      tables_clear();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 30;
      recv_idle_pct = 45;
      test_directed();
      test_random(170);
      send_idle_pct = 45;
      recv_idle_pct = 30;
      test_random(170);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_random(110);
      drain();
      if (error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end
endmodule

`default_nettype wire
